// File: rtl/frame_rate_drop_repeat_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef FRAME_RATE_DROP_REPEAT_SCHEDULER_DEFINES_SVH
`define FRAME_RATE_DROP_REPEAT_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FRDR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("frdr check failed");
// next-cycle implication
`define FRDR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("frdr check failed");
`else
`define FRDR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define FRDR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// File: rtl/frdr_pkg.sv
`default_nettype none
package frdr_pkg;

  localparam int TS_W       = 62;
  localparam int TIME_W     = 64;
  localparam int TICKS_W    = 30;
  localparam int FRAC_W     = 32;
  localparam int SLOT_W     = 4;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_REPEATS = 16;
  localparam int REPS_W      = $clog2(MAX_REPEATS + 1);

  localparam logic [TICKS_W-1:0] TICKS_RST = TICKS_W'(40000);
  localparam logic [FRAC_W-1:0]  FRAC_RST  = '0;
  localparam logic [FRAC_W-1:0]  RATE_RST  = FRAC_W'(25);

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_TICKS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_FRACTION = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUMERATOR    = CFG_IDX_W'(2);

  typedef enum logic [ACT_W-1:0] {
    ACT_EMIT    = 2'd0,
    ACT_REPEAT  = 2'd1,
    ACT_RELEASE = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    TSEL_ZERO  = 2'd0,
    TSEL_STAMP = 2'd1,
    TSEL_HOLD  = 2'd2
  } time_sel_t;

  typedef enum logic {
    SSEL_HELD = 1'b0,
    SSEL_IN   = 1'b1
  } slot_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_FLUSH_REL,
    ST_UNDATED_REL,
    ST_RESYNC_REL,
    ST_RESYNC_EMIT,
    ST_EARLY_REL,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      push;
    act_t      act;
    slot_sel_t slot_sel;
    time_sel_t time_sel;
    logic      last;
    logic      load_sched;
    logic      clear_sched;
    logic      advance;
    logic      capture;
    logic      reps_clr;
    logic      reps_inc;
    logic      set_hold;
    logic      clear_hold;
  } cmd_t;

  typedef struct packed {
    logic is_flush;
    logic undated;
    logic sched_invalid;
    logic late;
    logic early;
    logic reps_max;
    logic reps_zero;
    logic holding;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/frdr_if.sv
`default_nettype none
interface frdr_in_if import frdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SLOT_W-1:0] buffer_slot;
  logic [TS_W-1:0]   timestamp;

  modport source (output valid, output mode, output buffer_slot, output timestamp,
                  input ready);
  modport sink   (input valid, input mode, input buffer_slot, input timestamp,
                  output ready);
endinterface

interface frdr_out_if import frdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [SLOT_W-1:0] out_slot;
  logic [TS_W-1:0]   out_time;
  logic              last;

  modport source (output valid, output action, output out_slot, output out_time,
                  output last, input ready);
  modport sink   (input valid, input action, input out_slot, input out_time,
                  input last, output ready);
endinterface

interface frdr_cfg_if import frdr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/frdr_ctrl.sv
`default_nettype none
module frdr_ctrl import frdr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (sts.is_flush) begin
          if (sts.holding) begin
            state_nxt = ST_FLUSH_REL;
          end else begin
            cmd.clear_sched = 1'b1;
            cmd.clear_hold  = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else if (sts.undated) begin
          state_nxt = ST_UNDATED_REL;
        end else if (sts.sched_invalid || sts.late) begin
          cmd.load_sched = 1'b1;
          state_nxt      = sts.holding ? ST_RESYNC_REL : ST_RESYNC_EMIT;
        end else if (sts.early) begin
          if (sts.holding) begin
            state_nxt = ST_EARLY_REL;
          end else begin
            cmd.set_hold = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (sts.holding) begin
          // held frame goes out at the current schedule point
          cmd.capture  = 1'b1;
          cmd.advance  = 1'b1;
          cmd.reps_clr = 1'b1;
          state_nxt    = ST_RUN;
        end else begin
          cmd.set_hold = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FLUSH_REL: begin
        if (sts.out_free) begin
          cmd.push        = 1'b1;
          cmd.act         = ACT_RELEASE;
          cmd.slot_sel    = SSEL_HELD;
          cmd.time_sel    = TSEL_ZERO;
          cmd.last        = 1'b1;
          cmd.clear_sched = 1'b1;
          cmd.clear_hold  = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_UNDATED_REL: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.act      = ACT_RELEASE;
          cmd.slot_sel = SSEL_IN;
          cmd.time_sel = TSEL_ZERO;
          cmd.last     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RESYNC_REL: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.act      = ACT_RELEASE;
          cmd.slot_sel = SSEL_HELD;
          cmd.time_sel = TSEL_ZERO;
          state_nxt    = ST_RESYNC_EMIT;
        end
      end
      ST_RESYNC_EMIT: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.act      = ACT_EMIT;
          cmd.slot_sel = SSEL_IN;
          cmd.time_sel = TSEL_STAMP;
          cmd.last     = 1'b1;
          cmd.advance  = 1'b1;
          cmd.set_hold = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EARLY_REL: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.act      = ACT_RELEASE;
          cmd.slot_sel = SSEL_HELD;
          cmd.time_sel = TSEL_ZERO;
          cmd.last     = 1'b1;
          cmd.set_hold = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RUN: begin
        // push the captured item; last once the schedule has caught up or the repeat limit is reached
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.act      = sts.reps_zero ? ACT_EMIT : ACT_REPEAT;
          cmd.slot_sel = SSEL_HELD;
          cmd.time_sel = TSEL_HOLD;
          if (!sts.reps_max && sts.late) begin
            cmd.capture  = 1'b1;
            cmd.advance  = 1'b1;
            cmd.reps_inc = 1'b1;
          end else begin
            cmd.last     = 1'b1;
            cmd.set_hold = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/frdr_dp.sv
`default_nettype none
module frdr_dp import frdr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cfg_ready,
  input  logic                  in_mode,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [TS_W-1:0]       in_ts,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [ACT_W-1:0]      out_action,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [TS_W-1:0]       out_time,
  output logic                  out_last
);

  logic [TICKS_W-1:0] ticks_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [FRAC_W-1:0]  rate_r;

  logic               mode_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [TS_W-1:0]    ts_r;

  logic [TIME_W-1:0]  next_time_r, next_time_nxt;
  logic [FRAC_W-1:0]  frac_acc_r, frac_acc_nxt;
  logic               holding_r;
  logic [SLOT_W-1:0]  held_slot_r;
  logic [TIME_W-1:0]  time_hold_r;
  logic [REPS_W-1:0]  reps_r;

  logic               out_valid_r;
  logic [ACT_W-1:0]   out_action_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [TS_W-1:0]    out_time_r;
  logic               out_last_r;

  logic [FRAC_W-1:0]  num_eff;
  logic [FRAC_W-1:0]  frac_eff;
  logic [FRAC_W:0]    sum;
  logic [FRAC_W:0]    sum_sub;
  logic [FRAC_W:0]    sum_red;
  logic               carry;
  logic [TIME_W-1:0]  nt_plus;
  logic [TIME_W-1:0]  ts_plus;
  logic [TIME_W-1:0]  ts_ext;
  logic               out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RST;
      frac_r  <= FRAC_RST;
      rate_r  <= RATE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INTERVAL_TICKS:    ticks_r <= cfg_data[TICKS_W-1:0];
        CFG_INTERVAL_FRACTION: frac_r  <= cfg_data[FRAC_W-1:0];
        CFG_RATE_NUMERATOR:    rate_r  <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      slot_r <= in_slot;
      ts_r   <= in_ts;
    end
  end

  // one schedule step: whole ticks plus a carry out of the remainder
  always_comb begin
    num_eff  = (rate_r == '0) ? FRAC_W'(1) : rate_r;
    frac_eff = (frac_r < num_eff) ? frac_r : num_eff - FRAC_W'(1);
    sum      = {1'b0, frac_acc_r} + {1'b0, frac_eff};
    carry    = sum >= {1'b0, num_eff};
    sum_sub  = sum - {1'b0, num_eff};
    sum_red  = carry ? sum_sub : sum;
    if (sum_red >= {1'b0, num_eff}) begin
      sum_red = {1'b0, num_eff - FRAC_W'(1)};
    end
  end

  assign ts_ext  = {{(TIME_W-TS_W){1'b0}}, ts_r};
  assign nt_plus = next_time_r + {{(TIME_W-TICKS_W){1'b0}}, ticks_r};
  assign ts_plus = ts_ext + {{(TIME_W-TICKS_W){1'b0}}, ticks_r};

  always_comb begin
    next_time_nxt = next_time_r;
    frac_acc_nxt  = frac_acc_r;
    if (cmd.clear_sched) begin
      next_time_nxt = '0;
      frac_acc_nxt  = '0;
    end else if (cmd.load_sched) begin
      next_time_nxt = ts_ext;
      frac_acc_nxt  = '0;
    end else if (cmd.advance) begin
      next_time_nxt = nt_plus + {{(TIME_W-1){1'b0}}, carry};
      frac_acc_nxt  = sum_red[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_time_r <= '0;
      frac_acc_r  <= '0;
      holding_r   <= 1'b0;
      held_slot_r <= '0;
      reps_r      <= '0;
    end else begin
      next_time_r <= next_time_nxt;
      frac_acc_r  <= frac_acc_nxt;
      if (cmd.clear_hold) begin
        holding_r <= 1'b0;
      end else if (cmd.set_hold) begin
        holding_r   <= 1'b1;
        held_slot_r <= slot_r;
      end
      if (cmd.reps_clr) begin
        reps_r <= '0;
      end else if (cmd.reps_inc) begin
        reps_r <= reps_r + REPS_W'(1);
      end
    end
  end

  // schedule point of the item that is waiting to be pushed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      time_hold_r <= next_time_r;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_action_r <= cmd.act;
      out_slot_r   <= (cmd.slot_sel == SSEL_IN) ? slot_r : held_slot_r;
      out_last_r   <= cmd.last;
      case (cmd.time_sel)
        TSEL_STAMP: out_time_r <= ts_r;
        TSEL_HOLD:  out_time_r <= time_hold_r[TS_W-1:0];
        default:    out_time_r <= '0;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_slot   = out_slot_r;
  assign out_time   = out_time_r;
  assign out_last   = out_last_r;

  always_comb begin
    sts.is_flush      = mode_r;
    sts.undated       = ts_r == '0;
    sts.sched_invalid = next_time_r == '0;
    sts.late          = nt_plus < ts_ext;
    sts.early         = ts_plus < next_time_r;
    sts.reps_max      = reps_r == REPS_W'(MAX_REPEATS);
    sts.reps_zero     = reps_r == '0;
    sts.holding       = holding_r;
    sts.out_free      = out_free;
  end

endmodule
`default_nettype wire

// File: rtl/frame_rate_drop_repeat_scheduler.sv
// Channel   Dir   Handshake        Payload
// in_ch     in    valid / ready    mode, buffer_slot, timestamp
// out_ch    out   valid / ready    action, out_slot, out_time, last
// cfg_ch    in    valid / ready    index, data (always ready)
//
// An item is latched and is classified in the next cycle; each result is then
// pushed whenever the output register is free.
// The repeat loop is set by the schedule adder: one advance per repeat.
// rst_n is synchronous: schedule invalid, nothing held, registers at defaults.
// A stalled output holds the controller; in_ch.ready is high only when idle.
`default_nettype none
`include "frame_rate_drop_repeat_scheduler_defines.svh"
module frame_rate_drop_repeat_scheduler import frdr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  frdr_in_if.sink    in_ch,
  frdr_out_if.source out_ch,
  frdr_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  frdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frdr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .cfg_ready  (cfg_ch.ready),
    .in_mode    (in_ch.mode),
    .in_slot    (in_ch.buffer_slot),
    .in_ts      (in_ch.timestamp),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_action (out_ch.action),
    .out_slot   (out_ch.out_slot),
    .out_time   (out_ch.out_time),
    .out_last   (out_ch.last)
  );

  // one item in flight: never ready right after an accept
  `FRDR_ASSERT_NXT(a_one_item, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // a push never overwrites a result that is still stalled
  `FRDR_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.push, sts.out_free)
  // while a non-final result waits, the current item is not finished
  `FRDR_ASSERT_IMP(a_last_before_idle, clk, rst_n, out_ch.valid && !out_ch.last,
                   !in_ch.ready)
  // repeats stop at the limit
  `FRDR_ASSERT_IMP(a_reps_limit, clk, rst_n, sts.reps_max, !cmd.reps_inc)

endmodule
`default_nettype wire
